FILE: sv/form_url_percent_decoder_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef FORM_URL_PERCENT_DECODER_UNIT_MACROS_SVH
`define FORM_URL_PERCENT_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FUD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("form url decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FUD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("form url decoder: next-cycle check failed");

`endif

FILE: sv/fud_pkg.sv
package fud_pkg;

    localparam logic [7:0] MAX_OUT_LEN_RST = 8'd100;
    localparam int         QUEUE_DEPTH     = 2;
    localparam int         MAX_RESULTS     = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_out;

    // One accepted item's worth of results: n entries (1 to 4) in bytes[0..n-1].
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  n;
        logic                        has_byte;
        logic                        last;
    } t_cmd;

    function automatic logic [7:0] lead_tag(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h6D; // m
            2'd1: ch = 8'h73; // s
            2'd2: ch = 8'h67; // g
            2'd3: ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

FILE: sv/fud_front.sv
module fud_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fud_pkg::t_in  i_in_data,
    input  logic          i_q_full,
    output logic          o_push,
    output fud_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_NORMAL = 2'd1,
        PH_PCT    = 2'd2,
        PH_HEX1   = 2'd3
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_held, n_held;
    logic [7:0] r_first, n_first;
    logic [7:0] r_count, n_count;
    logic [7:0] r_max;

    logic       accept;
    logic [7:0] c;
    logic       is_end;

    logic       nb_n;
    logic [7:0] nb_b;
    logic       nb_pct;

    logic [1:0] nrep;
    logic [1:0] nex;
    logic [7:0] ex0, ex1;
    logic [2:0] ncand;
    logic [7:0] rem;
    logic [2:0] emit;
    logic [fud_pkg::MAX_RESULTS-1:0][7:0] cand;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign c          = i_in_data.char_in;
    assign is_end     = i_in_data.is_end;

    // Ordinary byte decode, shared by several phases.
    always_comb begin
        nb_n   = 1'b1;
        nb_b   = c;
        nb_pct = 1'b0;
        if (c == fud_pkg::CH_PLUS) begin
            nb_b = fud_pkg::CH_SPACE;
        end else if (c == fud_pkg::CH_PCT) begin
            if (is_end) begin
                nb_b = fud_pkg::CH_PCT;
            end else begin
                nb_n   = 1'b0;
                nb_pct = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_first = r_first;
        nrep    = 2'd0;
        nex     = 2'd0;
        ex0     = nb_b;
        ex1     = nb_b;

        unique case (r_phase)
            PH_PREFIX: begin
                if (c == fud_pkg::lead_tag(r_held)) begin
                    if (r_held == 2'd3) begin
                        n_phase = PH_NORMAL;
                        n_held  = 2'd0;
                    end else begin
                        n_held = r_held + 2'd1;
                        if (is_end) begin
                            nrep = r_held + 2'd1;
                        end
                    end
                end else begin
                    // replay the held part of the tag, then decode this byte
                    nrep    = r_held;
                    n_held  = 2'd0;
                    n_phase = nb_pct ? PH_PCT : PH_NORMAL;
                    nex     = {1'b0, nb_n};
                end
            end
            PH_NORMAL: begin
                nex = {1'b0, nb_n};
                if (nb_pct) begin
                    n_phase = PH_PCT;
                end
            end
            PH_PCT: begin
                if (is_end) begin
                    nex = 2'd1 + {1'b0, nb_n};
                    ex0 = fud_pkg::CH_PCT;
                end else begin
                    n_first = c;
                    n_phase = PH_HEX1;
                end
            end
            PH_HEX1: begin
                nex     = 2'd1;
                ex0     = {fud_pkg::hex_value(r_first), fud_pkg::hex_value(c)};
                n_phase = PH_NORMAL;
            end
            default: begin
                n_phase = PH_PREFIX;
            end
        endcase

        for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < nrep) begin
                cand[i] = fud_pkg::lead_tag(2'(i));
            end else if (2'(i) == nrep) begin
                cand[i] = ex0;
            end else begin
                cand[i] = ex1;
            end
        end

        ncand = {1'b0, nrep} + {1'b0, nex};
        rem   = (r_count >= r_max) ? 8'd0 : (r_max - r_count);
        emit  = ({5'd0, ncand} > rem) ? rem[2:0] : ncand;
        n_count = r_count + {5'd0, emit};

        if (is_end) begin
            n_phase = PH_PREFIX;
            n_held  = 2'd0;
            n_first = 8'd0;
            n_count = 8'd0;
        end

        o_cmd.bytes    = cand;
        o_cmd.n        = emit;
        o_cmd.has_byte = 1'b1;
        o_cmd.last     = is_end;
        if (emit == 3'd0) begin
            // end-only marker
            o_cmd.bytes[0] = 8'd0;
            o_cmd.n        = 3'd1;
            o_cmd.has_byte = 1'b0;
        end
        o_push = accept && ((emit != 3'd0) || is_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_held  <= 2'd0;
            r_first <= 8'd0;
            r_count <= 8'd0;
            r_max   <= fud_pkg::MAX_OUT_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_first <= n_first;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: sv/fud_queue.sv
module fud_queue #(
    parameter int DEPTH = fud_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fud_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output fud_pkg::t_cmd o_data,
    output logic          o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fud_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/fud_back.sv
module fud_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fud_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fud_pkg::t_out o_out_data
);

    logic          r_valid;
    fud_pkg::t_out r_data;
    logic [1:0]    r_idx;
    logic          load;
    logic          at_tail;

    assign load    = !r_valid || i_out_ready;
    assign at_tail = ({1'b0, r_idx} == (i_cmd.n - 3'd1));
    assign o_pop   = load && !i_empty && at_tail;

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                // advance through the head entry, drop it after its tail result
                r_idx <= at_tail ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data.out_byte <= i_cmd.bytes[r_idx];
            r_data.has_byte <= i_cmd.has_byte;
            r_data.out_last <= i_cmd.last && at_tail;
        end
    end

endmodule

FILE: sv/form_url_percent_decoder_unit.sv
// Form-encoded message decoder. One encoded byte is accepted per cycle whenever the
// command queue between the classifying front end and the output stage has room;
// each byte yields zero to four results (a held "msg=" prefix replayed, a decoded
// byte, a literal '%', or an end-only marker), and the output stage hands out one
// result per cycle while i_out_ready is high. A result passes through the queue and
// the output register before it appears.
// max_out_len is written through i_cfg_we / i_cfg_wdata and resets to 100.
module form_url_percent_decoder_unit #(
    parameter int QUEUE_DEPTH = fud_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fud_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fud_pkg::t_out o_out_data
);

    logic          push, pop, q_full, q_empty;
    fud_pkg::t_cmd cmd_in, cmd_head;

    fud_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (cmd_in)
    );

    fud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (cmd_head),
        .o_empty (q_empty)
    );

    fud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sv/fud_checker.sv
`include "form_url_percent_decoder_unit_macros.svh"

module fud_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_we,
    input logic [7:0]    i_cfg_wdata,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input fud_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input fud_pkg::t_out o_out_data
);

    // a stalled result holds
    `FUD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // an end-only marker carries a zero byte and closes the message
    `FUD_ASSERT_NOW(a_marker_shape, i_clk, i_rst_n, o_out_valid && !o_out_data.has_byte, o_out_data.out_last && (o_out_data.out_byte == 8'd0))

    // with the output stalled, a full queue cannot drain
    `FUD_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, !o_in_ready && o_out_valid && !i_out_ready, !o_in_ready)

endmodule

bind form_url_percent_decoder_unit fud_checker u_fud_checker (.*);
